### hw/rtl/kcl_pkg.sv
// Package: shared types, codes and sizes of the keypad code-lock controller.
`default_nettype none

package kcl_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int WIN_W       = 6;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd51;
  localparam logic [3:0]       DIGIT_MAX    = 4'd9;
  localparam logic [3:0]       CODE_RESET   = 4'd1;

  // event codes
  localparam logic [2:0] OP_POLL   = 3'd0;
  localparam logic [2:0] OP_KEY    = 3'd1;
  localparam logic [2:0] OP_ZONE1  = 3'd2;
  localparam logic [2:0] OP_ZONE2  = 3'd3;
  localparam logic [2:0] OP_CHANGE = 3'd4;

  localparam logic [1:0] ZONE_NONE = 2'd0;
  localparam logic [1:0] ZONE_ONE  = 2'd1;
  localparam logic [1:0] ZONE_TWO  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ENTRY   = 3'd1,
    MODE_OLD     = 3'd2,
    MODE_NEW     = 3'd3,
    MODE_CONFIRM = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_NONE     = 4'd0,
    ST_ALARM    = 4'd1,
    ST_DIGIT    = 4'd2,
    ST_WRONG    = 4'd3,
    ST_ACCEPT   = 4'd4,
    ST_TIMEOUT  = 4'd5,
    ST_OLD_OK   = 4'd6,
    ST_CONF_ASK = 4'd7,
    ST_STORED   = 4'd8,
    ST_MISMATCH = 4'd9,
    ST_REFUSED  = 4'd10
  } status_t;

  typedef logic [CODE_DIGITS-1:0][3:0] code_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [1:0] zone;
    logic [2:0] digit_position;
    logic [2:0] mode;
  } out_item_t;

  // handshake between the input register and the step logic
  typedef struct packed {
    logic valid;
    logic step;
  } step_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/keypad_code_lock_controller_unit.sv
// Top level of the keypad code-lock controller: channels, result register, wiring.
`default_nettype none

// Keypad code-lock controller for an intruder alarm. Each input transaction
// is one event (poll tick, key press, intrusion on zone 1 or 2, or a code
// change request) and yields exactly one result transaction carrying the
// status code plus the zone, digit position and mode after the event. An
// intrusion while idle opens an entry session that collects four digits and
// compares them digit by digit with the stored code (star, hash and other
// non-digit keys never match); polls and keys in the session count toward
// the entry window held in the cfg_ register, and reaching it raises a
// timeout. A change request while idle walks through old code, new code and
// confirmation, and stores the new code only when both entries match.
// Timing: one transaction per clock sustained while out_ready stays high.
// An accepted transaction sits in the input register, the step logic
// updates the lock state in a single pass, and the result is loaded into
// the output register when the step is taken. While a result waits with
// out_ready low, the result register and the input register hold, and
// in_ready drops once the input register is full; the input side keeps
// accepting whenever the result register is empty or drains. The cfg_ port
// is always ready; write it only while no transaction is in flight.

module keypad_code_lock_controller_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire kcl_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output kcl_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kcl_pkg::WIN_W-1:0]     cfg_data
);

  kcl_pkg::step_ctrl_t ctrl;
  kcl_pkg::in_item_t   item;
  kcl_pkg::out_item_t  result;
  kcl_pkg::out_item_t  out_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                step;

  // advance a held transaction whenever the result register is free or draining
  assign step = ctrl.valid && (!out_valid_r || out_ready);

  kcl_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .step     (step),
    .ctrl     (ctrl),
    .item     (item)
  );

  kcl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .item       (item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_window (cfg_data),
    .result     (result)
  );

  assign cfg_ready = 1'b1;

  // hold the result until taken; load a fresh one on every step
  assign out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/kcl_in_reg.sv
// Input register: holds one accepted transaction until the step logic takes it.
`default_nettype none

module kcl_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kcl_pkg::in_item_t in_data,
  input  wire logic              step,
  output kcl_pkg::step_ctrl_t    ctrl,
  output kcl_pkg::in_item_t      item
);

  logic              valid_r;
  logic              valid_nxt;
  kcl_pkg::in_item_t item_r;

  assign in_ready  = !valid_r || step;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign ctrl.valid = valid_r;
  assign ctrl.step  = step;
  assign item       = item_r;

endmodule

`default_nettype wire

### hw/rtl/kcl_core.sv
// Step logic: lock state, code buffers and the per-event update.
`default_nettype none

module kcl_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire kcl_pkg::step_ctrl_t                ctrl,
  input  wire kcl_pkg::in_item_t                  item,
  input  wire logic                               cfg_we,
  input  wire logic [kcl_pkg::WIN_W-1:0]          cfg_window,
  output kcl_pkg::out_item_t                      result
);

  function automatic logic codes_match(kcl_pkg::code_t a, kcl_pkg::code_t b);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < kcl_pkg::CODE_DIGITS; k++) begin
      if ((a[k] > kcl_pkg::DIGIT_MAX) || (a[k] != b[k])) ok = 1'b0;
    end
    return ok;
  endfunction

  kcl_pkg::mode_t               mode_r, mode_nxt;
  logic [kcl_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [kcl_pkg::WIN_W-1:0]    poll_r, poll_nxt, poll_inc;
  logic [kcl_pkg::WIN_W-1:0]    window_r;
  logic [1:0]                   zone_r, zone_nxt;
  kcl_pkg::code_t               ent_r, ent_nxt, ent_ins;
  kcl_pkg::code_t               pend_r, pend_nxt, pend_ins;
  kcl_pkg::code_t               stored_r, stored_nxt;
  kcl_pkg::status_t             status;
  logic [kcl_pkg::IDX_W-1:0]    idx;
  logic                         complete;
  logic                         timeout;
  logic                         entry_match;
  logic                         confirm_match;
  logic                         idle_go;

  assign idx      = cnt_r[kcl_pkg::IDX_W-1:0];
  assign cnt_inc  = cnt_r + 1'b1;
  assign complete = (cnt_inc >= kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS));
  assign poll_inc = poll_r + 1'b1;
  assign timeout  = (poll_inc >= window_r);

  always_comb begin
    ent_ins       = ent_r;
    ent_ins[idx]  = item.key_value;
    pend_ins      = pend_r;
    pend_ins[idx] = item.key_value;
  end

  assign entry_match   = codes_match(ent_ins, stored_r);
  assign confirm_match = codes_match(pend_r, ent_ins);

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    poll_nxt   = poll_r;
    zone_nxt   = zone_r;
    ent_nxt    = ent_r;
    pend_nxt   = pend_r;
    stored_nxt = stored_r;
    status     = kcl_pkg::ST_NONE;
    idle_go    = 1'b0;

    unique case (item.opcode)
      kcl_pkg::OP_POLL: begin
        if (mode_r == kcl_pkg::MODE_ENTRY) begin
          poll_nxt = poll_inc;
          if (timeout) begin
            status  = kcl_pkg::ST_TIMEOUT;
            idle_go = 1'b1;
          end
        end
      end
      kcl_pkg::OP_KEY: begin
        unique case (mode_r)
          kcl_pkg::MODE_ENTRY: begin
            poll_nxt = poll_inc;
            ent_nxt  = ent_ins;
            if (complete) begin
              cnt_nxt = '0;
              if (entry_match) begin
                status  = kcl_pkg::ST_ACCEPT;
                idle_go = 1'b1;
              end else begin
                status = kcl_pkg::ST_WRONG;
              end
            end else begin
              cnt_nxt = cnt_inc;
              status  = kcl_pkg::ST_DIGIT;
            end
            // the window overrides everything but an accepted code
            if (!(complete && entry_match) && timeout) begin
              status  = kcl_pkg::ST_TIMEOUT;
              idle_go = 1'b1;
            end
          end
          kcl_pkg::MODE_OLD: begin
            ent_nxt = ent_ins;
            if (complete) begin
              cnt_nxt = '0;
              if (entry_match) begin
                status   = kcl_pkg::ST_OLD_OK;
                mode_nxt = kcl_pkg::MODE_NEW;
              end else begin
                status  = kcl_pkg::ST_WRONG;
                idle_go = 1'b1;
              end
            end else begin
              cnt_nxt = cnt_inc;
              status  = kcl_pkg::ST_DIGIT;
            end
          end
          kcl_pkg::MODE_NEW: begin
            pend_nxt = pend_ins;
            if (complete) begin
              cnt_nxt  = '0;
              status   = kcl_pkg::ST_CONF_ASK;
              mode_nxt = kcl_pkg::MODE_CONFIRM;
            end else begin
              cnt_nxt = cnt_inc;
              status  = kcl_pkg::ST_DIGIT;
            end
          end
          kcl_pkg::MODE_CONFIRM: begin
            ent_nxt = ent_ins;
            if (complete) begin
              if (confirm_match) begin
                stored_nxt = pend_r;
                status     = kcl_pkg::ST_STORED;
              end else begin
                status = kcl_pkg::ST_MISMATCH;
              end
              idle_go = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
              status  = kcl_pkg::ST_DIGIT;
            end
          end
          default: begin
          end
        endcase
      end
      kcl_pkg::OP_ZONE1, kcl_pkg::OP_ZONE2: begin
        if (mode_r == kcl_pkg::MODE_IDLE) begin
          mode_nxt = kcl_pkg::MODE_ENTRY;
          zone_nxt = (item.opcode == kcl_pkg::OP_ZONE1) ? kcl_pkg::ZONE_ONE
                                                        : kcl_pkg::ZONE_TWO;
          cnt_nxt  = '0;
          poll_nxt = '0;
          status   = kcl_pkg::ST_ALARM;
        end
      end
      kcl_pkg::OP_CHANGE: begin
        if (mode_r == kcl_pkg::MODE_IDLE) begin
          mode_nxt = kcl_pkg::MODE_OLD;
          cnt_nxt  = '0;
        end else begin
          status = kcl_pkg::ST_REFUSED;
        end
      end
      default: begin
      end
    endcase

    if (idle_go) begin
      mode_nxt = kcl_pkg::MODE_IDLE;
      cnt_nxt  = '0;
      poll_nxt = '0;
      zone_nxt = kcl_pkg::ZONE_NONE;
    end
  end

  assign result.status         = status;
  assign result.zone           = zone_nxt;
  assign result.digit_position = 3'(cnt_nxt);
  assign result.mode           = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= kcl_pkg::MODE_IDLE;
    end else if (ctrl.step) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      poll_r   <= '0;
      zone_r   <= kcl_pkg::ZONE_NONE;
      ent_r    <= '0;
      pend_r   <= '0;
      stored_r <= {kcl_pkg::CODE_DIGITS{kcl_pkg::CODE_RESET}};
    end else if (ctrl.step) begin
      cnt_r    <= cnt_nxt;
      poll_r   <= poll_nxt;
      zone_r   <= zone_nxt;
      ent_r    <= ent_nxt;
      pend_r   <= pend_nxt;
      stored_r <= stored_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= kcl_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_window;
    end
  end

  // a step only ever happens on a held transaction
  a_step_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |-> ctrl.valid)
    else $error("step taken without a held transaction");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS))
    else $error("digit count out of range");

  a_zone_only_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == kcl_pkg::MODE_ENTRY) == (zone_r != kcl_pkg::ZONE_NONE))
    else $error("zone and entry mode disagree");

  a_poll_only_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != kcl_pkg::MODE_ENTRY) |-> (poll_r == '0))
    else $error("poll counter running outside entry");

  a_store_from_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(stored_r) |-> ($past(mode_r) == kcl_pkg::MODE_CONFIRM))
    else $error("stored code changed outside confirmation");

endmodule

`default_nettype wire
